[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files of the position indexer.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MRPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define MRPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/mrpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpi_pkg
// Types, constants and helpers for the multimodal rotary position indexer.
// ----------------------------------------------------------------------------
package mrpi_pkg;

  localparam int TOKEN_W  = 18;
  localparam int POS_W    = 20;
  localparam int VIDX_W   = 16;
  localparam int STEP_W   = 10;
  localparam int FRAME_W  = 6;   // frame counter, 0..63
  localparam int GRID_W   = 8;   // row / column counter, 0..255
  localparam int EXT_W    = 16;  // grid extent, up to 63 * 1023
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VISION_TOKEN_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPORAL_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS       = 3'd4;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic               first;
  } mrpi_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  t_position;
    logic [POS_W-1:0]  h_position;
    logic [POS_W-1:0]  w_position;
    logic              is_vision;
    logic [VIDX_W-1:0] vision_index;
  } mrpi_out_t;

  // Clip a grown position sum to the position range.
  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
    logic [POS_W-1:0] r;
    r = (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
    return r;
  endfunction

endpackage

[rtl/core/mrope_position_indexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrope_position_indexer_unit
// Gives temporal, height and width rotary positions for each prompt token.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | input     | in_valid / in_stall | mrpi_in_t  (token, first)
//  out_    | output    | out_valid/out_stall | mrpi_out_t (t/h/w, vision, index)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
//  One item per cycle sustained while out_ does not stall; an accepted item
//  goes from the input register into the result register, where it shows on
//  out_valid and can leave when out_stall is low.
//  The per-token state update (positions, grid counters) is one pass of
//  adds, small multiplies and compares between those two registers.
//  Reset (rst_n low, synchronous) empties both registers and clears the
//  position state and the configuration to 0, 0, 1, 1, 1.
//  A stall on out_ holds the result register; the input register then fills
//  and in_stall rises only once both hold an item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrope_position_indexer_unit
  import mrpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  mrpi_in_t              in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output mrpi_out_t             out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration, kept with the grid sizes already clipped and less one
  logic [TOKEN_W-1:0] vtid_r;
  logic [STEP_W-1:0]  step_r;
  logic [FRAME_W-1:0] frames_m1_r;
  logic [GRID_W-1:0]  rows_m1_r;
  logic [GRID_W-1:0]  cols_m1_r;

  // Prompt state
  logic [POS_W-1:0]   next_pos_r,  next_pos_nxt;
  logic [VIDX_W-1:0]  vcount_r,    vcount_nxt;
  logic [FRAME_W-1:0] frame_r,     frame_nxt;
  logic [GRID_W-1:0]  row_r,       row_nxt;
  logic [GRID_W-1:0]  col_r,       col_nxt;
  logic               in_block_r,  in_block_nxt;

  // Pipeline registers
  logic               stg_valid_r;
  mrpi_in_t           stg_item_r;
  logic               out_valid_r;
  mrpi_out_t          out_item_r;
  mrpi_out_t          res;

  logic advance;
  logic fire;

  // Effective state for the item in the input register (first clears it)
  logic [POS_W-1:0]   eff_next;
  logic [VIDX_W-1:0]  eff_vcount;
  logic [FRAME_W-1:0] eff_frame;
  logic [GRID_W-1:0]  eff_row;
  logic [GRID_W-1:0]  eff_col;
  logic               eff_in_block;

  logic               is_vis;
  logic [EXT_W-1:0]   t_off;
  logic [EXT_W-1:0]   ext_mul;
  logic [EXT_W-1:0]   ext;
  logic [POS_W-1:0]   base_pos;

  // Result register empties or moves on: the input register may hand over
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = stg_valid_r && advance;
  assign in_stall  = stg_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // ---------------------------------------------------------------------------
  // Configuration writes; out-of-range grid sizes clip to the legal range
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtid_r      <= '0;
      step_r      <= '0;
      frames_m1_r <= '0;
      rows_m1_r   <= '0;
      cols_m1_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VISION_TOKEN_ID: vtid_r <= cfg_wdata[TOKEN_W-1:0];
        CFG_TEMPORAL_STEP:   step_r <= cfg_wdata[STEP_W-1:0];
        CFG_FRAME_COUNT: begin
          if (cfg_wdata[6:0] == 7'd0) begin
            frames_m1_r <= '0;
          end else if (cfg_wdata[6:0] > 7'd64) begin
            frames_m1_r <= '1;
          end else begin
            frames_m1_r <= FRAME_W'(cfg_wdata[6:0] - 7'd1);
          end
        end
        CFG_GRID_ROWS: begin
          if (cfg_wdata[8:0] == 9'd0) begin
            rows_m1_r <= '0;
          end else if (cfg_wdata[8:0] > 9'd256) begin
            rows_m1_r <= '1;
          end else begin
            rows_m1_r <= GRID_W'(cfg_wdata[8:0] - 9'd1);
          end
        end
        CFG_GRID_COLS: begin
          if (cfg_wdata[8:0] == 9'd0) begin
            cols_m1_r <= '0;
          end else if (cfg_wdata[8:0] > 9'd256) begin
            cols_m1_r <= '1;
          end else begin
            cols_m1_r <= GRID_W'(cfg_wdata[8:0] - 9'd1);
          end
        end
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position logic for the item in the input register
  // ---------------------------------------------------------------------------
  always_comb begin
    eff_next     = stg_item_r.first ? '0 : next_pos_r;
    eff_vcount   = stg_item_r.first ? '0 : vcount_r;
    eff_frame    = stg_item_r.first ? '0 : frame_r;
    eff_row      = stg_item_r.first ? '0 : row_r;
    eff_col      = stg_item_r.first ? '0 : col_r;
    eff_in_block = stg_item_r.first ? 1'b0 : in_block_r;

    is_vis = (stg_item_r.token == vtid_r);

    // Temporal offset of this frame, and the largest grid extent of a block
    t_off   = EXT_W'({{(EXT_W-FRAME_W){1'b0}}, eff_frame} *
                     {{(EXT_W-STEP_W){1'b0}}, step_r});
    ext_mul = EXT_W'({{(EXT_W-FRAME_W){1'b0}}, frames_m1_r} *
                     {{(EXT_W-STEP_W){1'b0}}, step_r});
    ext = ext_mul;
    if ({{(EXT_W-GRID_W){1'b0}}, rows_m1_r} > ext) begin
      ext = {{(EXT_W-GRID_W){1'b0}}, rows_m1_r};
    end
    if ({{(EXT_W-GRID_W){1'b0}}, cols_m1_r} > ext) begin
      ext = {{(EXT_W-GRID_W){1'b0}}, cols_m1_r};
    end

    // Jump past the block that just ended
    base_pos = eff_in_block
             ? sat_pos({1'b0, eff_next} + {{(POS_W+1-EXT_W){1'b0}}, ext}
                       + (POS_W+1)'(1))
             : eff_next;

    next_pos_nxt = eff_next;
    vcount_nxt   = eff_vcount;
    frame_nxt    = eff_frame;
    row_nxt      = eff_row;
    col_nxt      = eff_col;
    in_block_nxt = eff_in_block;

    if (is_vis) begin
      res.t_position   = sat_pos({1'b0, eff_next} +
                                 {{(POS_W+1-EXT_W){1'b0}}, t_off});
      res.h_position   = sat_pos({1'b0, eff_next} +
                                 {{(POS_W+1-GRID_W){1'b0}}, eff_row});
      res.w_position   = sat_pos({1'b0, eff_next} +
                                 {{(POS_W+1-GRID_W){1'b0}}, eff_col});
      res.is_vision    = 1'b1;
      res.vision_index = eff_vcount;

      vcount_nxt   = eff_vcount + VIDX_W'(1);
      in_block_nxt = 1'b1;
      // Advance column, then row, then frame; wrap each at its extent
      if (eff_col >= cols_m1_r) begin
        col_nxt = '0;
        if (eff_row >= rows_m1_r) begin
          row_nxt   = '0;
          frame_nxt = (eff_frame >= frames_m1_r) ? '0 : eff_frame + FRAME_W'(1);
        end else begin
          row_nxt = eff_row + GRID_W'(1);
        end
      end else begin
        col_nxt = eff_col + GRID_W'(1);
      end
    end else begin
      res.t_position   = base_pos;
      res.h_position   = base_pos;
      res.w_position   = base_pos;
      res.is_vision    = 1'b0;
      res.vision_index = '0;

      in_block_nxt = 1'b0;
      next_pos_nxt = sat_pos({1'b0, base_pos} + (POS_W+1)'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Input register, result register and prompt state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      next_pos_r  <= '0;
      vcount_r    <= '0;
      frame_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      in_block_r  <= 1'b0;
    end else begin
      // Take a new item whenever the input register is free or moving on
      if (!in_stall) begin
        stg_valid_r <= in_valid;
        if (in_valid) begin
          stg_item_r <= in_data;
        end
      end
      if (advance) begin
        out_valid_r <= stg_valid_r;
        if (stg_valid_r) begin
          out_item_r <= res;
        end
      end
      // Commit state only when the item moves into the result register
      if (fire) begin
        next_pos_r <= next_pos_nxt;
        vcount_r   <= vcount_nxt;
        frame_r    <= frame_nxt;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        in_block_r <= in_block_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MRPI_ASSERT(a_ordinary_flat,
    out_valid_r && !out_item_r.is_vision |->
      (out_item_r.t_position == out_item_r.h_position) &&
      (out_item_r.h_position == out_item_r.w_position) &&
      (out_item_r.vision_index == '0),
    "ordinary token result has unequal axes or a vision index")
  `MRPI_ASSERT(a_stall_only_when_full,
    in_stall |-> stg_valid_r && out_valid_r && out_stall,
    "input stalled while the pipeline has room")
  `MRPI_ASSERT(a_vision_count_step,
    fire && is_vis && !stg_item_r.first |=> vcount_r == $past(vcount_r) + VIDX_W'(1),
    "vision count did not step on a vision token")
  `MRPI_ASSERT_ALWAYS(a_reset_empties,
    !rst_n |=> !out_valid_r && !stg_valid_r,
    "pipeline holds an item after reset")

endmodule
